### hw/rtl/bcdc_pkg.sv
// ----------------------------------------------------------------------------
// bcdc_pkg
// Shared types and constants for the BCD time-of-day clock with alarm.
// ----------------------------------------------------------------------------
package bcdc_pkg;

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_RUN   = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_LOAD  = 3'd3,
      CMD_CLEAR = 3'd4,
      CMD_ARM   = 3'd5
   } cmd_type;

   // Hours and minutes, as they arrive with a load or arm command.
   typedef struct packed {
      logic [1:0] hour_tens;
      logic [3:0] hour_units;
      logic [2:0] minute_tens;
      logic [3:0] minute_units;
   } hhmm_type;

   // Full time of day, most significant digit first.
   typedef struct packed {
      hhmm_type   hhmm;
      logic [2:0] second_tens;
      logic [3:0] second_units;
      logic [3:0] fraction_tens;
      logic [3:0] fraction_units;
   } time_type;

   // Step of the lowest fraction digit on each running tick.
   localparam logic [3:0] FRAC_STEP      = 4'd5;
   // Largest value of a decimal digit and of a tens digit counting to six.
   localparam logic [3:0] DEC_MAX        = 4'd9;
   localparam logic [2:0] SEX_MAX        = 3'd5;
   // Last hour of the day is 23.
   localparam logic [1:0] HOUR_TENS_MAX  = 2'd2;
   localparam logic [3:0] HOUR_UNITS_MAX = 4'd3;

endpackage

### hw/rtl/bcdc_intf.sv
// ----------------------------------------------------------------------------
// bcdc_intf
// Valid/ready channels for commands and for time results.
// ----------------------------------------------------------------------------
interface bcdc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [1:0] hour_tens_in;
   logic [3:0] hour_units_in;
   logic [2:0] minute_tens_in;
   logic [3:0] minute_units_in;

   modport source (
      output valid, command, hour_tens_in, hour_units_in, minute_tens_in,
             minute_units_in,
      input  ready
   );
   modport sink (
      input  valid, command, hour_tens_in, hour_units_in, minute_tens_in,
             minute_units_in,
      output ready
   );
endinterface

interface bcdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] hour_tens;
   logic [3:0] hour_units;
   logic [2:0] minute_tens;
   logic [3:0] minute_units;
   logic [2:0] second_tens;
   logic [3:0] second_units;
   logic [3:0] fraction_tens;
   logic [3:0] fraction_units;
   logic       alarm_fired;
   logic       load_error;

   modport source (
      output valid, hour_tens, hour_units, minute_tens, minute_units,
             second_tens, second_units, fraction_tens, fraction_units,
             alarm_fired, load_error,
      input  ready
   );
   modport sink (
      input  valid, hour_tens, hour_units, minute_tens, minute_units,
             second_tens, second_units, fraction_tens, fraction_units,
             alarm_fired, load_error,
      output ready
   );
endinterface

### hw/rtl/bcdc_advance.sv
// ----------------------------------------------------------------------------
// bcdc_advance
// One tick of the BCD counter: adds five hundredths and ripples the carry
// up through seconds, minutes and a 24-hour wrap.
// ----------------------------------------------------------------------------
module bcdc_advance
   import bcdc_pkg::*;
(
   input  time_type cur,
   output time_type nxt
);

   logic       c_fu, c_ft, c_su, c_st, c_mu, c_mt;
   logic [3:0] hu_inc;

   always_comb begin
      nxt = cur;

      // Carry out of each digit, only when the digit below carried.
      c_fu = (cur.fraction_units >= FRAC_STEP);
      c_ft = c_fu && (cur.fraction_tens >= DEC_MAX);
      c_su = c_ft && (cur.second_units >= DEC_MAX);
      c_st = c_su && (cur.second_tens >= SEX_MAX);
      c_mu = c_st && (cur.hhmm.minute_units >= DEC_MAX);
      c_mt = c_mu && (cur.hhmm.minute_tens >= SEX_MAX);
      hu_inc = cur.hhmm.hour_units + 4'd1;

      nxt.fraction_units = c_fu ? 4'd0 : cur.fraction_units + FRAC_STEP;
      if (c_fu) begin
         nxt.fraction_tens = c_ft ? 4'd0 : cur.fraction_tens + 4'd1;
      end
      if (c_ft) begin
         nxt.second_units = c_su ? 4'd0 : cur.second_units + 4'd1;
      end
      if (c_su) begin
         nxt.second_tens = c_st ? 3'd0 : cur.second_tens + 3'd1;
      end
      if (c_st) begin
         nxt.hhmm.minute_units = c_mu ? 4'd0 : cur.hhmm.minute_units + 4'd1;
      end
      if (c_mu) begin
         nxt.hhmm.minute_tens = c_mt ? 3'd0 : cur.hhmm.minute_tens + 3'd1;
      end
      if (c_mt) begin
         // Past 23:59 the day starts over at midnight.
         if (cur.hhmm.hour_tens >= HOUR_TENS_MAX && hu_inc > HOUR_UNITS_MAX) begin
            nxt.hhmm.hour_tens  = 2'd0;
            nxt.hhmm.hour_units = 4'd0;
         end else if (hu_inc > DEC_MAX) begin
            nxt.hhmm.hour_units = 4'd0;
            nxt.hhmm.hour_tens  = cur.hhmm.hour_tens + 2'd1;
         end else begin
            nxt.hhmm.hour_units = hu_inc;
         end
      end
   end

endmodule

### hw/rtl/bcdc_core.sv
// ----------------------------------------------------------------------------
// bcdc_core
// Clock and alarm state with command decode. Produces the time after the
// command and the two flags, and updates the state when step is high.
// ----------------------------------------------------------------------------
module bcdc_core
   import bcdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [2:0] command,
   input  hhmm_type   hhmm,
   output time_type   time_out,
   output logic       alarm_fired,
   output logic       load_error
);

   time_type time_ff, time_in, time_adv;
   hhmm_type alarm_ff, alarm_in;
   logic     running_ff, running_in;
   logic     armed_ff, armed_in;
   logic     hhmm_ok;

   bcdc_advance u_advance (
      .cur (time_ff),
      .nxt (time_adv)
   );

   always_comb begin
      hhmm_ok = (hhmm.hour_units <= DEC_MAX) && (hhmm.minute_tens <= SEX_MAX) &&
                (hhmm.minute_units <= DEC_MAX) && (hhmm.hour_tens <= HOUR_TENS_MAX) &&
                !(hhmm.hour_tens == HOUR_TENS_MAX && hhmm.hour_units > HOUR_UNITS_MAX);

      time_in     = time_ff;
      alarm_in    = alarm_ff;
      running_in  = running_ff;
      armed_in    = armed_ff;
      alarm_fired = 1'b0;
      load_error  = 1'b0;

      case (command)
         CMD_TICK: begin
            if (running_ff) begin
               time_in = time_adv;
               // The alarm looks at hours and minutes after the count moved.
               if (armed_ff && alarm_ff == time_adv.hhmm) begin
                  armed_in    = 1'b0;
                  alarm_fired = 1'b1;
               end
            end
         end
         CMD_RUN:   running_in = 1'b1;
         CMD_STOP:  running_in = 1'b0;
         CMD_LOAD: begin
            if (hhmm_ok) begin
               time_in      = '0;
               time_in.hhmm = hhmm;
            end else begin
               load_error = 1'b1;
            end
         end
         CMD_CLEAR: time_in = '0;
         CMD_ARM: begin
            if (hhmm_ok) begin
               alarm_in = hhmm;
               armed_in = 1'b1;
            end else begin
               load_error = 1'b1;
            end
         end
         default: ;
      endcase

      time_out = time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff    <= '0;
         alarm_ff   <= '0;
         running_ff <= 1'b0;
         armed_ff   <= 1'b0;
      end else if (step) begin
         time_ff    <= time_in;
         alarm_ff   <= alarm_in;
         running_ff <= running_in;
         armed_ff   <= armed_in;
      end
   end

endmodule

### hw/rtl/bcd_time_of_day_clock_alarm.sv
// ----------------------------------------------------------------------------
// bcd_time_of_day_clock_alarm
// 24-hour BCD clock HH:MM:SS.hh with a one-shot HH:MM alarm.
// ----------------------------------------------------------------------------
//   channel   direction   carries
//   req_if    in          command and HH:MM digits
//   rsp_if    out         time after the command, alarm_fired, load_error
//
// One command enters per cycle while rsp_if is not stalled; its result passes the
// input register and is offered to rsp_if from the result register.
// The carry chain and alarm compare sit between the input and result registers.
// Reset clears the time, the alarm and both valid flags; the clock is stopped.
// A stalled result register holds the input register, and req_if stays ready
// while either register has room.
// ----------------------------------------------------------------------------
module bcd_time_of_day_clock_alarm
   import bcdc_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   bcdc_req_if.sink   req_if,
   bcdc_rsp_if.source rsp_if
);

   logic       in_valid_ff, rsp_valid_ff;
   logic [2:0] cmd_ff;
   hhmm_type   hhmm_ff;
   time_type   time_next, time_ff;
   logic       fired_next, fired_ff, err_next, err_ff;
   logic       rsp_open, step;

   assign rsp_open     = !rsp_valid_ff || rsp_if.ready;
   assign step         = in_valid_ff && rsp_open;
   assign req_if.ready = !in_valid_ff || rsp_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         cmd_ff               <= req_if.command;
         hhmm_ff.hour_tens    <= req_if.hour_tens_in;
         hhmm_ff.hour_units   <= req_if.hour_units_in;
         hhmm_ff.minute_tens  <= req_if.minute_tens_in;
         hhmm_ff.minute_units <= req_if.minute_units_in;
      end
   end

   bcdc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .command     (cmd_ff),
      .hhmm        (hhmm_ff),
      .time_out    (time_next),
      .alarm_fired (fired_next),
      .load_error  (err_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_open) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         time_ff  <= time_next;
         fired_ff <= fired_next;
         err_ff   <= err_next;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.hour_tens      = time_ff.hhmm.hour_tens;
   assign rsp_if.hour_units     = time_ff.hhmm.hour_units;
   assign rsp_if.minute_tens    = time_ff.hhmm.minute_tens;
   assign rsp_if.minute_units   = time_ff.hhmm.minute_units;
   assign rsp_if.second_tens    = time_ff.second_tens;
   assign rsp_if.second_units   = time_ff.second_units;
   assign rsp_if.fraction_tens  = time_ff.fraction_tens;
   assign rsp_if.fraction_units = time_ff.fraction_units;
   assign rsp_if.alarm_fired    = fired_ff;
   assign rsp_if.load_error     = err_ff;

endmodule
